// ----- src/lirs_pkg.sv -----
// Shared types and constants of the linear interpolation resampler.
`default_nettype none

package lirs_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 19;
  localparam int FRAC_W    = 16;
  localparam int K_W       = 32;
  // Position numerators stay below 2^52: k*dst is below 2^51 and the
  // numerator never runs more than one source step past the window.
  localparam int NUM_W     = 52;
  localparam int CFG_IDX_W = 1;

  localparam logic [RATE_W-1:0]    RATE_RESET   = 19'd48000;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_RATE = 1'b1;

  localparam int MUL_MC_W  = K_W + 1;
  localparam int MUL_MP_W  = RATE_W;
  localparam int MUL_P_W   = NUM_W;
  localparam int MUL_CNT_W = $clog2(MUL_MP_W);
  localparam int DIV_CNT_W = $clog2(NUM_W + FRAC_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LO_MUL,
    ST_HOLD,
    ST_CHECK,
    ST_DIV,
    ST_MIX,
    ST_PLACE,
    ST_SKIP,
    ST_COMMIT,
    ST_DRAIN_RD,
    ST_DRAIN_WR
  } lirs_state_t;

  typedef struct packed {
    logic                start;
    logic [MUL_MC_W-1:0] mcand;
    logic [MUL_MP_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic              frac_mode;
    logic [NUM_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] rem;
    logic [FRAC_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/lirs_mul.sv -----
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier.
`default_nettype none

module lirs_mul
  import lirs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MUL_MC_W-1:0]  mc_r, mc_nxt;
  logic [MUL_MP_W-1:0]  mp_r, mp_nxt;
  logic [MUL_P_W-1:0]   acc_r, acc_nxt;
  logic [MUL_P_W-1:0]   mc_ext;
  logic                 last_step;

  assign mc_ext    = {{(MUL_P_W-MUL_MC_W){mc_r[MUL_MC_W-1]}}, mc_r};
  assign last_step = (cnt_r == MUL_CNT_W'(MUL_MP_W-1));

  // Multiplier bits are consumed most significant first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mc_nxt   = req.mcand;
      mp_nxt   = req.mplier;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {acc_r[MUL_P_W-2:0], 1'b0} + (mp_r[MUL_MP_W-1] ? mc_ext : '0);
      mp_nxt  = {mp_r[MUL_MP_W-2:0], 1'b0};
      cnt_nxt = cnt_r + MUL_CNT_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

`default_nettype wire

// ----- src/lirs_div.sv -----
// Bit-serial restoring divider giving a remainder and optional 16 fraction bits.
`default_nettype none

module lirs_div
  import lirs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 frac_r, frac_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     dvd_r, dvd_nxt;
  logic [RATE_W-1:0]    dvs_r, dvs_nxt;
  logic [RATE_W-1:0]    rem_r, rem_nxt;
  logic [FRAC_W-1:0]    quo_r, quo_nxt;
  logic [RATE_W:0]      trial, trial_sub;
  logic                 fits, last_step;

  // After the dividend bits run out, zeros shift in; the quotient bits of
  // those extra steps are the fraction floor(rem * 2^16 / divisor).
  assign trial     = {rem_r, dvd_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});
  assign last_step = frac_r ? (cnt_r == DIV_CNT_W'(NUM_W + FRAC_W - 1))
                            : (cnt_r == DIV_CNT_W'(NUM_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      frac_nxt = req.frac_mode;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
      dvd_nxt = {dvd_r[NUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[FRAC_W-2:0], fits};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

// ----- src/linear_interp_resampler_unit.sv -----
// Top level of the linear interpolation sample rate converter.
//
//   Channel  Direction  Handshake              Payload
//   in_      in         in_valid / in_stall    in_sample_in, in_end_of_stream
//   out_     out        out_valid / out_stall  out_sample_out, out_run_last,
//                                              out_stream_done, out_valid_res,
//                                              out_overflow
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is handled at a time. With equal rates an item goes straight to
// the commit and drain states. Otherwise the window product k*dst is formed
// on the serial multiplier, and each interpolated output uses the serial
// divider for the fraction, the multiplier for the mix and the check and
// place states. A truncated run uses the divider to realign the position.
// Each result drains through a buffer read and an output register write.
// Reset is synchronous and active low; it restores both rates to 48000 and
// clears the stream state. A stalled output holds its register; the input
// is taken again as soon as the last result of an item sits in that register.
`default_nettype none

module linear_interp_resampler_unit
  import lirs_pkg::*;
#(
  parameter int MAX_RUN = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                       in_end_of_stream,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_sample_out,
  output logic                            out_run_last,
  output logic                            out_stream_done,
  output logic                            out_valid_res,
  output logic                            out_overflow,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [RATE_W-1:0]          cfg_data
);

  localparam int IDX_W = $clog2(MAX_RUN);
  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int MIX_W = SAMPLE_W + FRAC_W + 4;
  localparam logic [MIX_W-1:0] ROUND_HALF = MIX_W'(1) << (FRAC_W - 1);

  // Control state and configuration.
  lirs_state_t          state_r, state_nxt;
  logic [RATE_W-1:0]    src_rate_r, src_rate_nxt;
  logic [RATE_W-1:0]    dst_rate_r, dst_rate_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [K_W-1:0]       k_r, k_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic                 hold_valid_r, hold_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Per-item working registers and result payload.
  logic signed [SAMPLE_W-1:0] s_r, s_nxt;
  logic                 e_r, e_nxt;
  logic [NUM_W-1:0]     lo_r, lo_nxt;
  logic [NUM_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [SAMPLE_W-1:0] v_r, v_nxt;
  logic signed [SAMPLE_W-1:0] hold_val_r, hold_val_nxt;
  logic [CNT_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                 out_run_last_r, out_run_last_nxt;
  logic                 out_done_r, out_done_nxt;
  logic                 out_vres_r, out_vres_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // Run buffer: results of one item are collected here, since the overflow
  // flag that every one of them carries is known only once the run ends.
  logic [SAMPLE_W-1:0]  res_mem [MAX_RUN];
  logic [SAMPLE_W-1:0]  mem_rd_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [SAMPLE_W-1:0]  mem_wd;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Decoded conditions.
  logic [RATE_W-1:0]    src_e, dst_e;
  logic                 eq_rates, in_take, out_free, out_load;
  logic                 cfg_we;
  logic                 num_ge_lo, past_hi, num_le_hi, cnt_full;
  logic [NUM_W:0]       num_plus_src;
  logic                 chk_done, chk_full, chk_tail;
  logic                 drain_last;
  logic signed [SAMPLE_W-1:0] mix_a;
  logic [SAMPLE_W:0]    mix_diff;
  logic [MIX_W-1:0]     mix_sum;
  logic [SAMPLE_W-1:0]  mix_val;
  logic [RATE_W-1:0]    skip_adj;

  // A rate register holding zero behaves as a rate of one.
  assign src_e    = (src_rate_r == '0) ? RATE_W'(1) : src_rate_r;
  assign dst_e    = (dst_rate_r == '0) ? RATE_W'(1) : dst_rate_r;
  assign eq_rates = (src_e == dst_e);

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Window tests against the current input: lo = k*dst, hi = (k+1)*dst.
  assign num_plus_src = {1'b0, num_r} + (NUM_W+1)'(src_e);
  assign num_ge_lo    = (num_r >= lo_r);
  assign num_le_hi    = (num_r <= hi_r);
  assign past_hi      = (num_plus_src > {1'b0, hi_r});
  assign cnt_full     = (cnt_r == CNT_W'(MAX_RUN));

  // Outputs lie strictly before the current sample until the stream ends;
  // the final sample closes the stream up to its end position.
  assign chk_done = (!e_r && num_ge_lo) || (e_r && past_hi);
  assign chk_full = !chk_done && cnt_full;
  assign chk_tail = !chk_done && !cnt_full && e_r && num_ge_lo;

  assign drain_last = (cnt_r == '0) || (rd_ptr_r == cnt_r - CNT_W'(1));

  // Mix: a + floor(((b - a) * frac + 2^15) / 2^16), with the first sample of a
  // stream standing in for its own missing predecessor.
  assign mix_a    = have_prev_r ? prev_r : s_r;
  assign mix_diff = {s_r[SAMPLE_W-1], s_r} - {mix_a[SAMPLE_W-1], mix_a};
  assign mix_sum  = {{(MIX_W-SAMPLE_W-FRAC_W){mix_a[SAMPLE_W-1]}}, mix_a, {FRAC_W{1'b0}}}
                  + mul_rsp.prod[MIX_W-1:0] + ROUND_HALF;
  assign mix_val  = mix_sum[FRAC_W +: SAMPLE_W];

  // Rounding the window start up to a whole source step after truncation.
  assign skip_adj = (div_rsp.rem == '0) ? '0 : (src_e - div_rsp.rem);

  lirs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  lirs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = eq_rates ? ST_COMMIT : ST_LO_MUL;
        end
      end
      ST_LO_MUL: begin
        if (mul_rsp.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (chk_done) begin
          state_nxt = ST_COMMIT;
        end else if (chk_full) begin
          state_nxt = e_r ? ST_COMMIT : ST_SKIP;
        end else if (chk_tail) begin
          state_nxt = ST_PLACE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (mul_rsp.done) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_nxt = (!e_r && past_hi) ? ST_COMMIT : ST_CHECK;
      end
      ST_SKIP: begin
        if (div_rsp.done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_DRAIN_RD;
      end
      ST_DRAIN_RD: begin
        state_nxt = ST_DRAIN_WR;
      end
      ST_DRAIN_WR: begin
        if (out_free) begin
          state_nxt = drain_last ? ST_IDLE : ST_DRAIN_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Unit requests, buffer writes and the output register load.
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    mul_req.start    = 1'b0;
    mul_req.mcand    = {{(MUL_MC_W-SAMPLE_W-1){mix_diff[SAMPLE_W]}}, mix_diff};
    mul_req.mplier   = MUL_MP_W'(div_rsp.quo);
    div_req.start    = 1'b0;
    div_req.frac_mode = 1'b1;
    div_req.dividend = num_r;
    div_req.divisor  = dst_e;
    mem_we           = 1'b0;
    mem_wa           = cnt_r[IDX_W-1:0];
    mem_wd           = v_r;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        mul_req.mcand  = {1'b0, k_r};
        mul_req.mplier = dst_e;
        if (in_take) begin
          mul_req.start = !eq_rates;
          mem_we        = eq_rates;
          mem_wa        = '0;
          mem_wd        = in_sample_in;
        end
      end
      ST_HOLD: begin
        mem_we = hold_valid_r && num_le_hi;
        mem_wd = hold_val_r;
      end
      ST_CHECK: begin
        if (chk_full && !e_r) begin
          div_req.start     = 1'b1;
          div_req.frac_mode = 1'b0;
          div_req.dividend  = lo_r;
          div_req.divisor   = src_e;
        end else if (!chk_done && !chk_full && !chk_tail) begin
          div_req.start = 1'b1;
        end
      end
      ST_DIV: begin
        mul_req.start = div_rsp.done;
      end
      ST_PLACE: begin
        mem_we = !(!e_r && past_hi);
      end
      ST_DRAIN_WR: begin
        out_load = out_free;
      end
      ST_LO_MUL, ST_MIX, ST_SKIP, ST_COMMIT, ST_DRAIN_RD: begin
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    src_rate_nxt     = src_rate_r;
    dst_rate_nxt     = dst_rate_r;
    prev_nxt         = prev_r;
    have_prev_nxt    = have_prev_r;
    k_nxt            = k_r;
    num_nxt          = num_r;
    hold_valid_nxt   = hold_valid_r;
    hold_val_nxt     = hold_val_r;
    s_nxt            = s_r;
    e_nxt            = e_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    cnt_nxt          = cnt_r;
    ovf_nxt          = ovf_r;
    v_nxt            = v_r;
    rd_ptr_nxt       = rd_ptr_r;
    out_sample_nxt   = out_sample_r;
    out_run_last_nxt = out_run_last_r;
    out_done_nxt     = out_done_r;
    out_vres_nxt     = out_vres_r;
    out_ovf_nxt      = out_ovf_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_RATE: src_rate_nxt = cfg_data;
        REG_DST_RATE: dst_rate_nxt = cfg_data;
      endcase
    end

    if (mem_we) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          s_nxt   = in_sample_in;
          e_nxt   = in_end_of_stream;
          cnt_nxt = eq_rates ? CNT_W'(1) : '0;
          ovf_nxt = 1'b0;
        end
      end
      ST_LO_MUL: begin
        if (mul_rsp.done) begin
          lo_nxt = mul_rsp.prod;
          hi_nxt = mul_rsp.prod + NUM_W'(dst_e);
        end
      end
      ST_HOLD: begin
        // A held output is released once the window reaches it, and
        // dropped if the stream ends before it does.
        if (hold_valid_r && (num_le_hi || e_r)) begin
          hold_valid_nxt = 1'b0;
        end
      end
      ST_CHECK: begin
        if (chk_full) begin
          ovf_nxt = 1'b1;
        end
        if (chk_tail) begin
          v_nxt = s_r;
        end
      end
      ST_MIX: begin
        if (mul_rsp.done) begin
          v_nxt = mix_val;
        end
      end
      ST_PLACE: begin
        num_nxt = num_plus_src[NUM_W-1:0];
        if (!e_r && past_hi) begin
          hold_val_nxt   = v_r;
          hold_valid_nxt = 1'b1;
        end
      end
      ST_SKIP: begin
        if (div_rsp.done) begin
          num_nxt = lo_r + NUM_W'(skip_adj);
        end
      end
      ST_COMMIT: begin
        rd_ptr_nxt = '0;
        if (e_r) begin
          prev_nxt       = '0;
          have_prev_nxt  = 1'b0;
          k_nxt          = '0;
          num_nxt        = '0;
          hold_valid_nxt = 1'b0;
        end else begin
          prev_nxt      = s_r;
          have_prev_nxt = 1'b1;
          k_nxt         = k_r + K_W'(1);
        end
      end
      ST_DRAIN_WR: begin
        if (out_load) begin
          out_sample_nxt   = (cnt_r == '0) ? '0 : mem_rd_r;
          out_run_last_nxt = drain_last;
          out_done_nxt     = drain_last && e_r;
          out_vres_nxt     = (cnt_r != '0);
          out_ovf_nxt      = ovf_r;
          if (!drain_last) begin
            rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          end
        end
      end
      ST_DIV, ST_DRAIN_RD: begin
      end
      default: begin
      end
    endcase

    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      src_rate_r   <= RATE_RESET;
      dst_rate_r   <= RATE_RESET;
      prev_r       <= '0;
      have_prev_r  <= 1'b0;
      k_r          <= '0;
      num_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      src_rate_r   <= src_rate_nxt;
      dst_rate_r   <= dst_rate_nxt;
      prev_r       <= prev_nxt;
      have_prev_r  <= have_prev_nxt;
      k_r          <= k_nxt;
      num_r        <= num_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r            <= s_nxt;
    e_r            <= e_nxt;
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    cnt_r          <= cnt_nxt;
    ovf_r          <= ovf_nxt;
    v_r            <= v_nxt;
    hold_val_r     <= hold_val_nxt;
    rd_ptr_r       <= rd_ptr_nxt;
    out_sample_r   <= out_sample_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_done_r     <= out_done_nxt;
    out_vres_r     <= out_vres_nxt;
    out_ovf_r      <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      res_mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= res_mem[rd_ptr_r[IDX_W-1:0]];
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_run_last    = out_run_last_r;
  assign out_stream_done = out_done_r;
  assign out_valid_res   = out_vres_r;
  assign out_overflow    = out_ovf_r;

`ifndef SYNTHESIS
  a_buffer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r != ST_IDLE)) |-> (cnt_r < CNT_W'(MAX_RUN)))
    else $error("run buffer written beyond its depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted item did not start processing");

  a_stream_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_COMMIT) && e_r) |=> (!hold_valid_r && !have_prev_r && (k_r == '0)))
    else $error("stream state not cleared after final sample");

  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_stream_done || !out_valid_res)) |-> out_run_last)
    else $error("stream end or empty marker without run end");
`endif

endmodule

`default_nettype wire

// ----- test/lirs_checker.sv -----
// Checker for the resampler: predicts each result from the accepted inputs and compares.
module lirs_checker
  import lirs_pkg::*;
#(
  parameter int RUN_LIMIT = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                       in_end_of_stream,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic signed [SAMPLE_W-1:0] out_sample_out,
  input  wire logic                       out_run_last,
  input  wire logic                       out_stream_done,
  input  wire logic                       out_valid_res,
  input  wire logic                       out_overflow,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [RATE_W-1:0]          cfg_data,
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       run_last;
    logic                       stream_done;
    logic                       valid_res;
    logic                       overflow;
  } rs_result_t;

  rs_result_t pending_outputs[$];
  rs_result_t got_res;
  rs_result_t want_res;

  logic [RATE_W-1:0]          src_rate_q;
  logic [RATE_W-1:0]          dst_rate_q;
  logic signed [SAMPLE_W-1:0] prev_smp;
  logic                       have_prev;
  logic [31:0]                seen_count;
  logic [63:0]                next_pos;
  logic                       held_valid;
  logic signed [SAMPLE_W-1:0] held_value;

  int err_count = 0;
  int pending_q = 0;

  assign errors  = err_count;
  assign pending = pending_q;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("%0t: %s", $time, msg);
  endtask

  task automatic clear_stream();
    prev_smp   = '0;
    have_prev  = 1'b0;
    seen_count = '0;
    next_pos   = '0;
    held_valid = 1'b0;
    held_value = '0;
  endtask

  // Linear mix of a and b by frac/65536, rounded to nearest (floor of x + 0.5).
  function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] a,
                                                       input logic signed [SAMPLE_W-1:0] b,
                                                       input logic [FRAC_W-1:0] frac);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] wf;
    logic signed [63:0] t;
    wa = a;
    wb = b;
    wf = {48'd0, frac};
    t = wa * 64'sd65536 + (wb - wa) * wf + 64'sd32768;
    return t[31:16];
  endfunction

  task automatic resample_step(input logic signed [SAMPLE_W-1:0] smp, input logic eos);
    logic signed [SAMPLE_W-1:0] run_vals [RUN_LIMIT];
    logic signed [SAMPLE_W-1:0] prv;
    logic signed [SAMPLE_W-1:0] v;
    logic [63:0]                src;
    logic [63:0]                dst;
    logic [63:0]                k;
    logic [63:0]                lo;
    logic [63:0]                hi;
    logic [63:0]                num;
    logic [63:0]                skip;
    logic [63:0]                fr64;
    rs_result_t                 r;
    int                         cnt;
    bit                         ovf;
    bit                         stop;
    cnt  = 0;
    ovf  = 1'b0;
    stop = 1'b0;
    src  = (src_rate_q == '0) ? 64'd1 : {45'd0, src_rate_q};
    dst  = (dst_rate_q == '0) ? 64'd1 : {45'd0, dst_rate_q};
    k    = {32'd0, seen_count};

    if (src == dst) begin
      run_vals[0] = smp;
      cnt = 1;
    end else begin
      lo  = k * dst;
      hi  = (k + 64'd1) * dst;
      prv = have_prev ? prev_smp : smp;
      // A held output is released once this input proves it inside the stream.
      if (held_valid) begin
        if (next_pos <= hi) begin
          run_vals[cnt] = held_value;
          cnt++;
          held_valid = 1'b0;
        end else if (eos) begin
          held_valid = 1'b0;
        end
      end
      while (!stop) begin
        num = next_pos;
        if (!eos && num >= lo) begin
          stop = 1'b1;
        end else if (eos && num + src > hi) begin
          stop = 1'b1;
        end else if (cnt >= RUN_LIMIT) begin
          ovf = 1'b1;
          if (!eos) begin
            skip = (lo + src - 64'd1) / src;
            next_pos = skip * src;
          end
          stop = 1'b1;
        end else begin
          if (eos && num / dst >= k) begin
            v = smp;
          end else begin
            fr64 = ((num % dst) << 16) / dst;
            v = blend(prv, smp, fr64[FRAC_W-1:0]);
          end
          next_pos = num + src;
          if (!eos && num + src > hi) begin
            held_value = v;
            held_valid = 1'b1;
            stop = 1'b1;
          end else begin
            run_vals[cnt] = v;
            cnt++;
          end
        end
      end
    end

    prev_smp  = smp;
    have_prev = 1'b1;
    seen_count++;
    if (eos) clear_stream();

    if (cnt == 0) begin
      r.smp         = '0;
      r.run_last    = 1'b1;
      r.stream_done = eos;
      r.valid_res   = 1'b0;
      r.overflow    = ovf;
      pending_outputs.push_back(r);
    end else begin
      for (int i = 0; i < cnt; i++) begin
        r.smp         = run_vals[i];
        r.run_last    = (i == cnt - 1);
        r.stream_done = (i == cnt - 1) && eos;
        r.valid_res   = 1'b1;
        r.overflow    = ovf;
        pending_outputs.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      src_rate_q = RATE_RESET;
      dst_rate_q = RATE_RESET;
      clear_stream();
      pending_outputs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_RATE: src_rate_q = cfg_data;
          REG_DST_RATE: dst_rate_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) resample_step(in_sample_in, in_end_of_stream);
      if (out_valid && !out_stall) begin
        got_res = '{out_sample_out, out_run_last, out_stream_done, out_valid_res, out_overflow};
        if (pending_outputs.size() == 0) begin
          report_mismatch($sformatf("result with no expectation: sample %0d last %b done %b",
                                    out_sample_out, out_run_last, out_stream_done));
        end else begin
          want_res = pending_outputs.pop_front();
          if (got_res !== want_res)
            report_mismatch($sformatf(
              "got sample %0d last %b done %b vld %b ovf %b, want %0d %b %b %b %b",
              got_res.smp, got_res.run_last, got_res.stream_done, got_res.valid_res,
              got_res.overflow, want_res.smp, want_res.run_last, want_res.stream_done,
              want_res.valid_res, want_res.overflow));
        end
      end
    end
    pending_q <= pending_outputs.size();
  end

endmodule

// ----- test/tb_linear_interp_resampler_unit.sv -----
// Testbench top for the linear interpolation resampler: stimulus, flow control and verdict.
module tb_linear_interp_resampler_unit;
  import lirs_pkg::*;

  localparam int RUN_LIMIT = 16;

  // Number of random input transfers aimed for after the directed part.
  localparam int RANDOM_ITEMS = 400;

  // Length of the single long receiver hold-off, in clock cycles.
  localparam int HOLD_OFF_CYCLES = 400;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in     = '0;
  logic                       in_end_of_stream = 1'b0;
  logic                       out_valid;
  logic                       out_stall        = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_run_last;
  logic                       out_stream_done;
  logic                       out_valid_res;
  logic                       out_overflow;
  logic                       cfg_valid        = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index        = '0;
  logic [RATE_W-1:0]          cfg_data         = '0;

  int errors;
  int pending;

  // Random idling on both channels is switched off for one stretch of the run.
  logic idle_on     = 1'b1;
  // Raised once by the stimulus to ask the receiver for its long hold-off.
  logic pressure_go = 1'b0;

  always #2 clk = ~clk;

  linear_interp_resampler_unit #(
    .MAX_RUN (RUN_LIMIT)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_run_last     (out_run_last),
    .out_stream_done  (out_stream_done),
    .out_valid_res    (out_valid_res),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  lirs_checker #(
    .RUN_LIMIT (RUN_LIMIT)
  ) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_run_last     (out_run_last),
    .out_stream_done  (out_stream_done),
    .out_valid_res    (out_valid_res),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .pending          (pending)
  );

  // Offers one sample and returns at the edge where the transfer takes place.
  // The valid is left high there, so that a following call may keep it high
  // without a drop in between; gaps are made only before an offer.
  task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic eos);
    if (idle_on) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_sample_in     <= smp;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every predicted result has been seen,
  // then lets the requested extra cycles pass. The checker's count is
  // registered, so the first edge is always waited out before looking at it.
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Writes both rates back to back while the block is idle. The valid stays
  // high across the two transfers and is lowered after the second.
  task automatic write_rates(input logic [RATE_W-1:0] rs, input logic [RATE_W-1:0] rd);
    wait_idle(4);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SRC_RATE;
    cfg_data  <= rs;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_DST_RATE;
    cfg_data  <= rd;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stalls at random while idling is on, and once in the run holds
  // off for a long stretch so that the block fills up and stalls its input.
  initial begin : receiver
    int  hold_cnt;
    bit  hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        hold_cnt = 0;
        while (hold_cnt < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
      end
      out_stall <= idle_on && ($urandom_range(99) < 30);
    end
  end

  initial begin : stimulus
    logic [RATE_W-1:0]          rs;
    logic [RATE_W-1:0]          rd;
    logic signed [SAMPLE_W-1:0] smp;
    int unsigned                base;
    int unsigned                eff_s;
    int unsigned                eff_d;
    int                         len;
    int                         sent;

    // Synchronous reset, held at the start and never asserted again.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Equal rates straight after reset: samples must pass through unchanged,
    // including both extremes of the sample range.
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh0000, 1'b1);

    // A zero source rate counts as one, giving a threefold upsample. The
    // first sample of the stream stands in for its missing predecessor.
    write_rates(19'd0, 19'd3);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh0000, 1'b1);

    // Twenty outputs per input exceed the run limit: each run after the empty
    // first is cut short and flagged, and the position skips the dropped outputs.
    write_rates(19'd1, 19'd20);
    send_item(16'sd100, 1'b0);
    send_item(-16'sd100, 1'b0);
    send_item(16'sd5, 1'b1);

    // A zero destination rate counts as one: downsampling by three gives
    // empty runs and outputs that are held until a later input confirms them.
    write_rates(19'd3, 19'd0);
    send_item(16'sd1000, 1'b0);
    send_item(-16'sd2000, 1'b0);
    send_item(16'sd3000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sd7, 1'b1);

    // Rates changed in the middle of a stream: positions carry on with the
    // new ratio while the stream state is kept.
    write_rates(19'd2, 19'd5);
    send_item(16'sd1234, 1'b0);
    send_item(-16'sd4321, 1'b0);
    write_rates(19'd7, 19'd3);
    send_item(16'sd20000, 1'b0);
    send_item(-16'sd20000, 1'b0);
    send_item(16'sd9, 1'b1);

    // Extreme register values in both directions.
    write_rates(19'd384000, 19'd1);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b1);
    write_rates(19'd1, 19'd384000);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);

    // Random part: whole streams under random rates, with the odd rate
    // change in mid-stream as the noise. Upsampling ratios stay within eight
    // for most streams so that the run stays short; ratios past the run
    // limit get very short streams.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: begin
          rs = $urandom_range(1, 384000);
          rd = rs;
        end
        1: begin
          if ($urandom_range(1)) begin
            rs = '0;
            rd = $urandom_range(1, 8);
          end else begin
            rs = $urandom_range(1, 48000);
            rd = '0;
          end
        end
        2: begin
          rs = $urandom_range(1) ? 19'd384000 : 19'd1;
          rd = $urandom_range(1) ? 19'd384000 : 19'd1;
        end
        3, 4, 5, 6: begin
          base = $urandom_range(8000, 48000);
          rs   = base;
          rd   = (base * 8 > 384000) ? $urandom_range(base, 384000)
                                     : $urandom_range(base, base * 8);
        end
        default: begin
          base = $urandom_range(8000, 384000);
          rs   = base;
          rd   = $urandom_range(base / 8 + 1, base);
        end
      endcase
      write_rates(rs, rd);

      eff_s = (rs == '0) ? 1 : rs;
      eff_d = (rd == '0) ? 1 : rd;
      len   = (eff_d > 16 * eff_s) ? $urandom_range(1, 3) : $urandom_range(1, 24);

      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(19) == 0) begin
          base = $urandom_range(8000, 48000);
          write_rates(base, $urandom_range(base / 4, base * 4));
        end
        case ($urandom_range(7))
          0:       smp = 16'sh7FFF;
          1:       smp = 16'sh8000;
          default: smp = $urandom;
        endcase
        send_item(smp, i == len - 1);
        sent++;
        // The long receiver hold-off comes early; later a stretch of the run
        // goes without any idling on either side.
        if (sent == 60)  pressure_go <= 1'b1;
        if (sent == 150) idle_on <= 1'b0;
        if (sent == 240) idle_on <= 1'b1;
      end
    end

    // Drain: every prediction must be matched, then a quiet spell catches
    // any stray result transfer.
    wait_idle(200);

    if (errors == 0) begin
      $display("** linear_interp_resampler_unit: PASSED **");
    end else begin
      $display("** linear_interp_resampler_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every input producing
  // a full truncated run and each result waiting out the longest stall.
  initial begin : watchdog
    #20000000;
    $display("** linear_interp_resampler_unit: FAILED **");
    $finish;
  end

endmodule

// ----- linear_interp_resampler_unit.f -----
src/lirs_pkg.sv
src/lirs_mul.sv
src/lirs_div.sv
src/linear_interp_resampler_unit.sv
test/lirs_checker.sv
test/tb_linear_interp_resampler_unit.sv
